FILE: rtl/core/wrq_pkg.sv
// shared types, constants and ring helpers for the work ring queue
package wrq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CPU_COUNT   = 8;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int ADDR_W = 64;
    localparam int CNT_W  = 6;
    localparam int DROP_W = 32;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CPU_W-1:0] t_cpu_idx;

    typedef enum logic [1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_DEQUEUE  = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_COMPLETE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_CRD,
        S_CCMP,
        S_BUSY,
        S_DONE
    } t_state;

    // wrap at the ring end, depth need not be a power of two
    function automatic t_ptr ring_next(input t_ptr p);
        t_ptr q;
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + t_ptr'(1);
        end
        return q;
    endfunction

    // items between read and write pointer
    function automatic t_ptr ring_pending(input t_ptr wr, input t_ptr rd);
        logic [PTR_W:0] t;
        t = {1'b0, wr} - {1'b0, rd};
        if (wr < rd) begin
            t = t + (PTR_W+1)'(QUEUE_DEPTH);
        end
        return t[PTR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/work_ring_queue_with_range_cancel_unit.sv
// top level of the work ring queue with range cancel: sequencer, pointers and result register
//
// Ring queue of work items (function address plus context word) in a slot
// memory of wrq_pkg::QUEUE_DEPTH entries, one of which always stays empty.
// Each command beat gives exactly one result beat. Enqueue and complete go
// from idle straight to the result state, dequeue passes one more state
// for its registered memory read. Cancel walks the queued items through
// the one read port and one write port of the slot memory and then tests
// every in-flight record through the single range comparator. Input
// ready is low while a command is at work. The result sits in an output
// register, so the next command beat is taken while a result still waits.
module work_ring_queue_with_range_cancel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_func_addr,
    input  logic [63:0] i_ctx_word,
    input  logic [2:0]  i_cpu_index,
    input  logic [63:0] i_range_base,
    input  logic [63:0] i_range_length,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [63:0] o_out_func,
    output logic [63:0] o_out_ctx,
    output logic [5:0]  o_removed_count,
    output logic        o_busy_in_range,
    output logic [5:0]  o_pending_count,
    output logic [31:0] o_drop_total
);

    localparam int AW = wrq_pkg::ADDR_W;
    localparam int SW = 2 * AW;

    // sequencer and ring state
    wrq_pkg::t_state   r_state, n_state;
    wrq_pkg::t_ptr     r_rd_ptr, n_rd_ptr;
    wrq_pkg::t_ptr     r_wr_ptr, n_wr_ptr;
    logic [wrq_pkg::DROP_W-1:0] r_drop, n_drop;
    logic [AW-1:0]     r_running [wrq_pkg::CPU_COUNT];
    logic [AW-1:0]     n_running [wrq_pkg::CPU_COUNT];

    // per-command working registers
    wrq_pkg::t_ptr     r_walk_rd, n_walk_rd;
    wrq_pkg::t_ptr     r_walk_wr, n_walk_wr;
    wrq_pkg::t_cpu_idx r_cnt, n_cnt;
    wrq_pkg::t_cpu_idx r_cpu, n_cpu;
    logic              r_cpu_ok, n_cpu_ok;
    logic              r_deq_hit, n_deq_hit;
    logic [AW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_len, n_len;

    // result held until the output register is free
    logic              r_res_ok, n_res_ok;
    logic [AW-1:0]     r_res_func, n_res_func;
    logic [AW-1:0]     r_res_ctx, n_res_ctx;
    wrq_pkg::t_ptr     r_res_removed, n_res_removed;
    logic              r_res_busy, n_res_busy;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [AW-1:0]     r_out_func, n_out_func;
    logic [AW-1:0]     r_out_ctx, n_out_ctx;
    logic [5:0]        r_out_removed, n_out_removed;
    logic              r_out_busy, n_out_busy;
    logic [5:0]        r_out_pending, n_out_pending;
    logic [31:0]       r_out_drop, n_out_drop;

    // slot memory port controls
    logic              ram_wr_en;
    wrq_pkg::t_ptr     ram_wr_addr;
    logic [SW-1:0]     ram_wr_data;
    logic              ram_rd_en;
    wrq_pkg::t_ptr     ram_rd_addr;
    logic [SW-1:0]     ram_rd_data;

    // shared range comparator
    logic [AW-1:0]     cmp_addr;
    logic              cmp_hit;

    logic              in_beat;
    wrq_pkg::t_cmd     in_cmd;
    logic              in_cpu_ok;
    wrq_pkg::t_ptr     wr_next;

    assign in_beat   = i_in_valid && o_in_ready;
    assign in_cmd    = wrq_pkg::t_cmd'(i_command);
    assign in_cpu_ok = int'(i_cpu_index) < wrq_pkg::CPU_COUNT;
    assign wr_next   = wrq_pkg::ring_next(r_wr_ptr);

    // the comparator sees slot data during the walk, in-flight records after it
    assign cmp_addr = (r_state == wrq_pkg::S_BUSY) ? r_running[r_cnt]
                                                    : ram_rd_data[SW-1:AW];

    wrq_slot_ram #(
        .DEPTH (wrq_pkg::QUEUE_DEPTH),
        .WIDTH (SW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    wrq_range_cmp u_range_cmp (
        .i_addr (cmp_addr),
        .i_base (r_base),
        .i_len  (r_len),
        .o_hit  (cmp_hit)
    );

    always_comb begin
        n_state       = r_state;
        n_rd_ptr      = r_rd_ptr;
        n_wr_ptr      = r_wr_ptr;
        n_drop        = r_drop;
        n_running     = r_running;
        n_walk_rd     = r_walk_rd;
        n_walk_wr     = r_walk_wr;
        n_cnt         = r_cnt;
        n_cpu         = r_cpu;
        n_cpu_ok      = r_cpu_ok;
        n_deq_hit     = r_deq_hit;
        n_base        = r_base;
        n_len         = r_len;
        n_res_ok      = r_res_ok;
        n_res_func    = r_res_func;
        n_res_ctx     = r_res_ctx;
        n_res_removed = r_res_removed;
        n_res_busy    = r_res_busy;
        n_out_valid   = r_out_valid;
        n_out_ok      = r_out_ok;
        n_out_func    = r_out_func;
        n_out_ctx     = r_out_ctx;
        n_out_removed = r_out_removed;
        n_out_busy    = r_out_busy;
        n_out_pending = r_out_pending;
        n_out_drop    = r_out_drop;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_ptr;
        ram_wr_data = {i_func_addr, i_ctx_word};
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_ptr;

        o_in_ready = (r_state == wrq_pkg::S_IDLE);

        // output beat taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            wrq_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_res_ok      = 1'b0;
                    n_res_func    = '0;
                    n_res_ctx     = '0;
                    n_res_removed = '0;
                    n_res_busy    = 1'b0;
                    n_base        = i_range_base;
                    n_len         = i_range_length;
                    n_cpu         = wrq_pkg::t_cpu_idx'(i_cpu_index);
                    n_cpu_ok      = in_cpu_ok;
                    n_state       = wrq_pkg::S_DONE;
                    unique case (in_cmd)
                        wrq_pkg::CMD_ENQUEUE: begin
                            if (i_func_addr != '0) begin
                                if (wr_next == r_rd_ptr) begin
                                    // full ring, saturating drop count
                                    if (r_drop != '1) begin
                                        n_drop = r_drop + 1'b1;
                                    end
                                end else begin
                                    ram_wr_en = 1'b1;
                                    n_wr_ptr  = wr_next;
                                    n_res_ok  = 1'b1;
                                end
                            end
                        end
                        wrq_pkg::CMD_DEQUEUE: begin
                            n_deq_hit = (r_rd_ptr != r_wr_ptr);
                            ram_rd_en = 1'b1;
                            n_state   = wrq_pkg::S_DEQ;
                        end
                        wrq_pkg::CMD_CANCEL: begin
                            n_walk_rd = r_rd_ptr;
                            n_walk_wr = r_rd_ptr;
                            n_cnt     = '0;
                            n_state   = wrq_pkg::S_CRD;
                        end
                        wrq_pkg::CMD_COMPLETE: begin
                            if (in_cpu_ok) begin
                                n_running[wrq_pkg::t_cpu_idx'(i_cpu_index)] = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            wrq_pkg::S_DEQ: begin
                if (r_deq_hit) begin
                    n_res_ok   = 1'b1;
                    n_res_func = ram_rd_data[SW-1:AW];
                    n_res_ctx  = ram_rd_data[AW-1:0];
                    n_rd_ptr   = wrq_pkg::ring_next(r_rd_ptr);
                    if (r_cpu_ok) begin
                        n_running[r_cpu] = ram_rd_data[SW-1:AW];
                    end
                end
                n_state = wrq_pkg::S_DONE;
            end

            // cancel walk: read one slot
            wrq_pkg::S_CRD: begin
                if (r_walk_rd == r_wr_ptr) begin
                    n_wr_ptr = r_walk_wr;
                    n_state  = wrq_pkg::S_BUSY;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_walk_rd;
                    n_walk_rd   = wrq_pkg::ring_next(r_walk_rd);
                    n_state     = wrq_pkg::S_CCMP;
                end
            end

            // cancel walk: drop the slot or compact it down to the write side
            wrq_pkg::S_CCMP: begin
                if (cmp_hit) begin
                    n_res_removed = r_res_removed + 1'b1;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_walk_wr;
                    ram_wr_data = ram_rd_data;
                    n_walk_wr   = wrq_pkg::ring_next(r_walk_wr);
                end
                n_state = wrq_pkg::S_CRD;
            end

            // in-flight records, one per cycle
            wrq_pkg::S_BUSY: begin
                if (cmp_hit) begin
                    n_res_busy = 1'b1;
                end
                if (int'(r_cnt) == wrq_pkg::CPU_COUNT - 1) begin
                    n_state = wrq_pkg::S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            wrq_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_ok      = r_res_ok;
                    n_out_func    = r_res_func;
                    n_out_ctx     = r_res_ctx;
                    n_out_removed = 6'(r_res_removed);
                    n_out_busy    = r_res_busy;
                    n_out_pending = 6'(wrq_pkg::ring_pending(r_wr_ptr, r_rd_ptr));
                    n_out_drop    = r_drop;
                    n_state       = wrq_pkg::S_IDLE;
                end
            end

            default: n_state = wrq_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wrq_pkg::S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < wrq_pkg::CPU_COUNT; k++) begin
                r_running[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            r_running   <= n_running;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_walk_rd     <= n_walk_rd;
        r_walk_wr     <= n_walk_wr;
        r_cnt         <= n_cnt;
        r_cpu         <= n_cpu;
        r_cpu_ok      <= n_cpu_ok;
        r_deq_hit     <= n_deq_hit;
        r_base        <= n_base;
        r_len         <= n_len;
        r_res_ok      <= n_res_ok;
        r_res_func    <= n_res_func;
        r_res_ctx     <= n_res_ctx;
        r_res_removed <= n_res_removed;
        r_res_busy    <= n_res_busy;
        r_out_ok      <= n_out_ok;
        r_out_func    <= n_out_func;
        r_out_ctx     <= n_out_ctx;
        r_out_removed <= n_out_removed;
        r_out_busy    <= n_out_busy;
        r_out_pending <= n_out_pending;
        r_out_drop    <= n_out_drop;
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_out_func      = r_out_func;
    assign o_out_ctx       = r_out_ctx;
    assign o_removed_count = r_out_removed;
    assign o_busy_in_range = r_out_busy;
    assign o_pending_count = r_out_pending;
    assign o_drop_total    = r_out_drop;

endmodule

FILE: rtl/core/wrq_slot_ram.sv
// simple dual-port slot store, one write and one registered read per cycle
module wrq_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/wrq_range_cmp.sv
// shared range test: a in [base, base+len) with unsigned wrap-free arithmetic
module wrq_range_cmp (
    input  logic [wrq_pkg::ADDR_W-1:0] i_addr,
    input  logic [wrq_pkg::ADDR_W-1:0] i_base,
    input  logic [wrq_pkg::ADDR_W-1:0] i_len,
    output logic                       o_hit
);

    logic [wrq_pkg::ADDR_W:0] diff;

    // borrow out of the subtract says addr < base
    assign diff  = {1'b0, i_addr} - {1'b0, i_base};
    assign o_hit = !diff[wrq_pkg::ADDR_W] && (diff[wrq_pkg::ADDR_W-1:0] < i_len);

endmodule
